// File: hw/rtl/max_min_degree_lower_bound_defines.svh
// Assertion macros for the maximum-minimum-degree lower bound block.
`ifndef MAX_MIN_DEGREE_LOWER_BOUND_DEFINES_SVH
`define MAX_MIN_DEGREE_LOWER_BOUND_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MMDLB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mmdlb: check failed");

// next-cycle implication, disabled while reset is asserted
`define MMDLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mmdlb: check failed");

`endif

// File: hw/rtl/mmdlb_pkg.sv
// Types, constants and the population count shared by the lower bound block.
`timescale 1ns / 1ps

package mmdlb_pkg;

	localparam int unsigned MAX_VERTICES = 64;
	localparam int unsigned DEG_W        = 7;
	localparam int unsigned BOUND_W      = 6;
	localparam logic [BOUND_W-1:0] BOUND_MAX = 6'd63;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SWEEP,
		ST_DRAIN,
		ST_OUT
	} state_t;

	function automatic logic [DEG_W-1:0] popcount64(input logic [MAX_VERTICES-1:0] x);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int i = 0; i < 32; i++) begin
			l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		end
		return {1'b0, l5[0]} + {1'b0, l5[1]};
	endfunction

endpackage

// File: hw/rtl/max_min_degree_lower_bound.sv
// Maximum-minimum-degree lower bound over a stored graph and vertex subset.
`timescale 1ns / 1ps

// Load beats (tuser 0) write one adjacency row into the row memory and set or clear
// the vertex's subset bit; they give no result. A run beat (tuser 1) copies the subset
// into a working set and repeatedly sweeps the row memory, one row read a cycle through
// a three-stage read, mask and count pipeline, keeping the first vertex of least degree;
// each sweep removes that vertex and folds its degree into the running maximum. Each
// removal takes a check, a sweep and a pipeline drain; sweeps stop once fewer than two
// members remain.
// The row memory needs no clearing pass: per-row valid bits make unwritten rows read as
// zero. The result waits in an output register, and loads are taken while it waits.

`include "max_min_degree_lower_bound_defines.svh"

module max_min_degree_lower_bound #(
	parameter int unsigned VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // vertex[5:0], neighbours[69:6], in_subset[70], zero[71]
	input  logic        s_tuser,   // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // lower_bound[5:0], zero[7:6]
);

	localparam int unsigned AW = $clog2(VERTICES);

	logic [5:0]                 in_vertex;
	logic [VERTICES-1:0]        in_row;
	logic                       in_subset;
	logic                       in_acc;
	logic                       load_we;

	logic [VERTICES-1:0]        mem [VERTICES];
	logic [VERTICES-1:0]        row_vld_q;
	logic [VERTICES-1:0]        subset_q;
	logic [VERTICES-1:0]        rem_q;
	logic [AW-1:0]              cnt_q;
	mmdlb_pkg::state_t          state_q, state_d;

	logic                       v_s1, v_s2, v_s3;
	logic [VERTICES-1:0]        row_s1;
	logic                       row_vld_s1;
	logic [AW-1:0]              idx_s1, idx_s2, idx_s3;
	logic [VERTICES-1:0]        masked_s2;
	logic                       member_s2, member_s3;
	logic [mmdlb_pkg::DEG_W-1:0] deg_s3;

	logic                       found_q;
	logic [AW-1:0]              best_v_q;
	logic [mmdlb_pkg::DEG_W-1:0] best_d_q;
	logic [mmdlb_pkg::BOUND_W-1:0] max_q;
	logic [mmdlb_pkg::BOUND_W-1:0] sat_d;
	logic                       out_vld_q;
	logic [mmdlb_pkg::BOUND_W-1:0] out_q;

	logic                       two_plus;
	logic                       pipe_empty;
	logic                       issue, start_sweep, do_remove, do_out;

	assign in_vertex = s_tdata[5:0];
	assign in_row    = s_tdata[6 +: VERTICES];
	assign in_subset = s_tdata[70];

	assign s_tready  = (state_q == mmdlb_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign load_we   = in_acc && (s_tuser == mmdlb_pkg::MODE_LOAD)
		&& ({1'b0, in_vertex} < 7'(VERTICES));

	assign two_plus   = (rem_q & (rem_q - VERTICES'(1))) != '0;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign sat_d      = (best_d_q > {1'b0, mmdlb_pkg::BOUND_MAX}) ? mmdlb_pkg::BOUND_MAX
		: best_d_q[mmdlb_pkg::BOUND_W-1:0];

	always_comb begin
		state_d     = state_q;
		issue       = 1'b0;
		start_sweep = 1'b0;
		do_remove   = 1'b0;
		do_out      = 1'b0;
		unique case (state_q)
			mmdlb_pkg::ST_IDLE: begin
				if (in_acc && (s_tuser == mmdlb_pkg::MODE_RUN)) begin
					state_d = mmdlb_pkg::ST_CHECK;
				end
			end
			mmdlb_pkg::ST_CHECK: begin
				if (two_plus) begin
					start_sweep = 1'b1;
					state_d     = mmdlb_pkg::ST_SWEEP;
				end else begin
					state_d = mmdlb_pkg::ST_OUT;
				end
			end
			mmdlb_pkg::ST_SWEEP: begin
				issue = 1'b1;
				if (cnt_q == AW'(VERTICES - 1)) begin
					state_d = mmdlb_pkg::ST_DRAIN;
				end
			end
			mmdlb_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					do_remove = 1'b1;
					state_d   = mmdlb_pkg::ST_CHECK;
				end
			end
			mmdlb_pkg::ST_OUT: begin
				if (!out_vld_q || m_tready) begin
					do_out  = 1'b1;
					state_d = mmdlb_pkg::ST_IDLE;
				end
			end
			default: state_d = mmdlb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmdlb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row memory: written on loads, read once per cycle during a sweep
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[in_vertex[AW-1:0]] <= in_row;
		end
		row_s1     <= mem[cnt_q];
		row_vld_s1 <= row_vld_q[cnt_q];
		idx_s1     <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			subset_q  <= '0;
			rem_q     <= '0;
			max_q     <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_we) begin
				row_vld_q[in_vertex[AW-1:0]] <= 1'b1;
				subset_q[in_vertex[AW-1:0]]  <= in_subset;
			end
			if (in_acc && (s_tuser == mmdlb_pkg::MODE_RUN)) begin
				rem_q <= subset_q;
				max_q <= '0;
			end
			if (start_sweep) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if (issue) begin
				cnt_q <= AW'(cnt_q + 1'b1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && member_s3 && (!found_q || (deg_s3 < best_d_q))) begin
				found_q <= 1'b1;
			end
			if (do_remove) begin
				rem_q[best_v_q] <= 1'b0;
				if (sat_d > max_q) begin
					max_q <= sat_d;
				end
			end
			if (do_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// mask and count stages, best-vertex tracking
	always_ff @(posedge clk) begin
		masked_s2 <= (row_vld_s1 ? row_s1 : '0) & rem_q;
		member_s2 <= rem_q[idx_s1];
		idx_s2    <= idx_s1;
		deg_s3    <= mmdlb_pkg::popcount64(mmdlb_pkg::MAX_VERTICES'(masked_s2));
		member_s3 <= member_s2;
		idx_s3    <= idx_s2;
		if (v_s3 && member_s3 && (!found_q || (deg_s3 < best_d_q))) begin
			best_v_q <= idx_s3;
			best_d_q <= deg_s3;
		end
		if (do_out) begin
			out_q <= max_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_q};

	`MMDLB_ASSERT_NOW(a_ready_pipe_idle, clk, arst_n, s_tready, pipe_empty)
	`MMDLB_ASSERT_NOW(a_sweep_has_pair, clk, arst_n,
		state_q == mmdlb_pkg::ST_SWEEP, two_plus)
	`MMDLB_ASSERT_NOW(a_remove_has_best, clk, arst_n, do_remove,
		found_q && rem_q[best_v_q])
	`MMDLB_ASSERT_NEXT(a_out_raises_valid, clk, arst_n, do_out, m_tvalid)

endmodule
